// ----- hdl/ws2812_spi_bit_encoder_defines.svh -----
// ----------------------------------------------------------------------------
// ws2812 spi bit encoder assertion macros
// shared concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef WS2812_SPI_BIT_ENCODER_DEFINES_SVH
`define WS2812_SPI_BIT_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WSE_ASSERT_HOLDS(label, clk_i, rstn_i, cond) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (cond)) \
        else $error("wse assertion failed: invariant");
`define WSE_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("wse assertion failed: next-cycle check");
`else
`define WSE_ASSERT_HOLDS(label, clk_i, rstn_i, cond)
`define WSE_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons)
`endif

`endif

// ----- hdl/wse_pkg.sv -----
// ----------------------------------------------------------------------------
// wse_pkg
// types, constants and the symbol encoder for the ws2812 spi bit encoder
// ----------------------------------------------------------------------------
`default_nettype none

package wse_pkg;

    localparam int MAX_LEDS = 64;

    localparam int LIMIT_W = 7;
    localparam int GAP_W   = 8;
    localparam int COLOR_W = 24;
    localparam int WORD_W  = 40;
    localparam int CFG_W   = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
    localparam logic [GAP_W-1:0]   GAP_RESET   = 8'd150;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP   = LIMIT_W'(MAX_LEDS);

    localparam logic [4:0] SYM_ONE  = 5'h1C;
    localparam logic [4:0] SYM_ZERO = 5'h10;

    typedef enum logic [0:0] {
        CFG_FRAME_LED_LIMIT = 1'b0,
        CFG_RESET_GAP_BYTES = 1'b1
    } wse_cfg_idx_t;

    typedef enum logic [1:0] {
        SEL_G   = 2'd0,
        SEL_R   = 2'd1,
        SEL_B   = 2'd2,
        SEL_GAP = 2'd3
    } wse_sel_t;

    function automatic logic [WORD_W-1:0] encode_byte(input logic [7:0] v);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int k = 0; k < 8; k++)
        begin
            w[k*5 +: 5] = v[k] ? SYM_ONE : SYM_ZERO;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ws2812_spi_bit_encoder.sv -----
// ----------------------------------------------------------------------------
// ws2812_spi_bit_encoder
// Turns one 0xRRGGBB color per item into three 40-bit spi symbol words
// (G, R, B, msb first at bit 39) and a reset-gap item at the end of a frame.
//
// Input channel in_valid / in_stall carries led_color and frame_end. Output
// channel out_valid / out_stall carries symbol_word, is_gap, gap_length and
// last_of_run. An item moves on an edge with valid high and stall low.
// An accepted color is held in an item register, and the result sequencer
// loads one result per cycle into the output register while it is not
// stalled, so a result passes the item register, then the output register.
// A color yields its G, R and B words, then a gap item with frame_end; a
// dropped color yields only the gap item with frame_end, none without it.
// The next item is taken in the cycle its predecessor issues its last result.
// A stalled output holds its result and backs up the item register, which
// then stalls the input. Colors beyond min(frame_led_limit, 64) in a frame
// are dropped. Reset empties both registers, clears the frame counter and
// sets the registers to a limit of 64 and a gap of 150 bytes.
// Configuration writes are taken on any edge with cfg_write_en high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ws2812_spi_bit_encoder_defines.svh"

module ws2812_spi_bit_encoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [wse_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic [wse_pkg::COLOR_W-1:0]   led_color,
    input  wire logic                          frame_end,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic [wse_pkg::WORD_W-1:0]    symbol_word,
    output      logic                          is_gap,
    output      logic [wse_pkg::GAP_W-1:0]     gap_length,
    output      logic                          last_of_run
);

    logic [wse_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic [wse_pkg::GAP_W-1:0]   gap_reg, gap_next;
    logic [wse_pkg::LIMIT_W-1:0] leds_reg, leds_next;

    logic                        item_valid_reg, item_valid_next;
    wse_pkg::wse_sel_t           item_sel_reg, item_sel_next;
    logic [wse_pkg::COLOR_W-1:0] item_color_reg, item_color_next;
    logic                        item_fend_reg, item_fend_next;

    logic                        out_valid_reg, out_valid_next;
    logic [wse_pkg::WORD_W-1:0]  word_reg, word_next;
    logic                        is_gap_reg, is_gap_next;
    logic [wse_pkg::GAP_W-1:0]   gap_len_reg, gap_len_next;
    logic                        last_reg, last_next;

    logic                        out_free;
    logic                        load;
    logic                        item_last;
    logic                        accept;
    logic [wse_pkg::LIMIT_W-1:0] eff_limit;
    logic                        encode_en;

    assign out_free  = !out_valid_reg || !out_stall;
    assign load      = item_valid_reg && out_free;
    assign item_last = (item_sel_reg == wse_pkg::SEL_GAP) ||
                       ((item_sel_reg == wse_pkg::SEL_B) && !item_fend_reg);
    assign in_stall  = item_valid_reg && !(load && item_last);
    assign accept    = in_valid && !in_stall;
    assign eff_limit = (limit_reg > wse_pkg::LIMIT_CAP) ? wse_pkg::LIMIT_CAP : limit_reg;
    assign encode_en = leds_reg < eff_limit;

    // configuration registers
    always_comb
    begin
        limit_next = limit_reg;
        gap_next   = gap_reg;
        if (cfg_write_en)
        begin
            case (wse_pkg::wse_cfg_idx_t'(cfg_index))
                wse_pkg::CFG_FRAME_LED_LIMIT: limit_next = cfg_data[wse_pkg::LIMIT_W-1:0];
                wse_pkg::CFG_RESET_GAP_BYTES: gap_next   = cfg_data[wse_pkg::GAP_W-1:0];
                default:                      limit_next = limit_reg;
            endcase
        end
    end

    // frame counter and item register
    always_comb
    begin
        leds_next       = leds_reg;
        item_valid_next = item_valid_reg;
        item_sel_next   = item_sel_reg;
        item_color_next = item_color_reg;
        item_fend_next  = item_fend_reg;
        if (load)
        begin
            if (item_last)
            begin
                item_valid_next = 1'b0;
            end
            else
            begin
                item_sel_next = wse_pkg::wse_sel_t'(item_sel_reg + 2'd1);
            end
        end
        if (accept)
        begin
            item_valid_next = encode_en || frame_end;
            item_sel_next   = encode_en ? wse_pkg::SEL_G : wse_pkg::SEL_GAP;
            item_color_next = led_color;
            item_fend_next  = frame_end;
            if (frame_end)
            begin
                leds_next = '0;
            end
            else if (encode_en)
            begin
                leds_next = leds_reg + 7'd1;
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        is_gap_next    = is_gap_reg;
        gap_len_next   = gap_len_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            is_gap_next    = 1'b0;
            gap_len_next   = '0;
            last_next      = item_last;
            case (item_sel_reg)
                wse_pkg::SEL_G: word_next = wse_pkg::encode_byte(item_color_reg[15:8]);
                wse_pkg::SEL_R: word_next = wse_pkg::encode_byte(item_color_reg[23:16]);
                wse_pkg::SEL_B: word_next = wse_pkg::encode_byte(item_color_reg[7:0]);
                wse_pkg::SEL_GAP:
                begin
                    word_next    = '0;
                    is_gap_next  = 1'b1;
                    gap_len_next = gap_reg;
                end
                default: word_next = '0;
            endcase
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= wse_pkg::LIMIT_RESET;
            gap_reg        <= wse_pkg::GAP_RESET;
            leds_reg       <= '0;
            item_valid_reg <= 1'b0;
            item_sel_reg   <= wse_pkg::SEL_G;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            limit_reg      <= limit_next;
            gap_reg        <= gap_next;
            leds_reg       <= leds_next;
            item_valid_reg <= item_valid_next;
            item_sel_reg   <= item_sel_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_color_reg <= item_color_next;
        item_fend_reg  <= item_fend_next;
        word_reg       <= word_next;
        is_gap_reg     <= is_gap_next;
        gap_len_reg    <= gap_len_next;
        last_reg       <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign symbol_word = word_reg;
    assign is_gap      = is_gap_reg;
    assign gap_length  = gap_len_reg;
    assign last_of_run = last_reg;

    `WSE_ASSERT_HOLDS(a_gap_is_final, clk, rst_n,
        !(out_valid_reg && is_gap_reg) || (word_reg == '0 && last_reg))
    `WSE_ASSERT_HOLDS(a_count_in_limit, clk, rst_n, leds_reg <= wse_pkg::LIMIT_CAP)
    `WSE_ASSERT_NEXT(a_item_drains, clk, rst_n, item_valid_reg && !out_stall, out_valid_reg)

endmodule

`default_nettype wire
